### rtl/lvp_pkg.sv
// ----------------------------------------------------------------------------
// lvp_pkg
// Shared widths, register codes and the column tag for the light
// view-projection matrix builder.
// ----------------------------------------------------------------------------
package lvp_pkg;

  localparam int OUT_FRAC_BITS_DEF = 12;

  localparam int DIR_W   = 16;
  localparam int MAG_W   = 16;
  localparam int CFG_W   = 15;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int SQ_W    = 31;
  localparam int N2_W    = 32;
  localparam int VX_W    = 51;
  localparam int E2_W    = 30;
  localparam int PNM_W   = 63;
  localparam int LO_W    = 32;
  localparam int A_W     = 63;
  localparam int B_W     = 93;
  localparam int VAL_W   = 16;
  localparam int COL_W   = 2;
  localparam int NROW    = 3;
  localparam int NCOL    = 4;

  localparam logic [VX_W-1:0] VERT_SCALE = VX_W'(1000000);

  localparam int DIV_STEPS  = 32;
  localparam int SQRT_STEPS = 16;
  localparam int ROOT_LAT   = DIV_STEPS + SQRT_STEPS + 2;
  localparam int ITEM_GAP   = 4;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(NCOL - 1);

  localparam logic [ADDR_W-3:0] REG_LIGHT_DISTANCE = 2'd0;
  localparam logic [ADDR_W-3:0] REG_ORTHO_EXTENT   = 2'd1;
  localparam logic [ADDR_W-3:0] REG_DEPTH_RANGE    = 2'd2;

  typedef struct packed {
    logic             vld;
    logic [COL_W-1:0] col;
    logic             deg;
    logic             last;
  } tag_t;

endpackage

### rtl/lvp_root.sv
// ----------------------------------------------------------------------------
// lvp_root
// Pipelined entry unit: round(mag * 2^(8+F) / (s * sqrt(d))) from
// a = mag^2 and b = s^2 * d, by long division then digit-by-digit root.
// ----------------------------------------------------------------------------
module lvp_root import lvp_pkg::*; #(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic [A_W-1:0]   a,
  input  logic [B_W-1:0]   b,
  input  logic             neg,
  output logic [VAL_W-1:0] value
);

  localparam int SHIFT = 2 * OUT_FRAC_BITS - 14;
  localparam int REM_W = B_W + 1;

  typedef struct packed {
    logic ovf;
    logic neg;
    logic zero;
  } root_flag_t;

  logic [REM_W-1:0]     rem [DIV_STEPS];
  logic [B_W-1:0]       den [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo [DIV_STEPS+1];
  root_flag_t           fl  [DIV_STEPS+1];

  logic [DIV_STEPS-1:0] num [1:SQRT_STEPS-1];
  logic [DIV_STEPS-1:0] res [1:SQRT_STEPS];
  root_flag_t           sf  [1:SQRT_STEPS];

  logic [DIV_STEPS-1:0] num0;
  root_flag_t           sf0;

  logic [REM_W-1:0] a_sh;
  assign a_sh = REM_W'(a) << SHIFT;

  always_ff @(posedge clk) begin
    rem[0]     <= a_sh;
    den[0]     <= b;
    quo[0]     <= '0;
    fl[0].ovf  <= a_sh >= REM_W'(b);
    fl[0].neg  <= neg;
    fl[0].zero <= a == '0;
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    logic [REM_W-1:0] t;
    logic             ge;
    assign t  = {rem[k-1][REM_W-2:0], 1'b0};
    assign ge = t >= REM_W'(den[k-1]);
    always_ff @(posedge clk) begin
      quo[k] <= {quo[k-1][DIV_STEPS-2:0], ge};
      fl[k]  <= fl[k-1];
    end
    if (k < DIV_STEPS) begin : g_carry
      always_ff @(posedge clk) begin
        rem[k] <= ge ? t - REM_W'(den[k-1]) : t;
        den[k] <= den[k-1];
      end
    end
  end

  // quotient saturates once it would pass the word width
  assign num0 = fl[DIV_STEPS].ovf ? '1 : quo[DIV_STEPS];
  assign sf0  = fl[DIV_STEPS];

  for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [DIV_STEPS-1:0] BIT = DIV_STEPS'(1) << (2 * (SQRT_STEPS - k));
    logic [DIV_STEPS-1:0] nin;
    logic [DIV_STEPS-1:0] rin;
    root_flag_t           fin;
    logic [DIV_STEPS-1:0] trial;
    logic                 ge;
    if (k == 1) begin : g_head
      assign nin = num0;
      assign rin = '0;
      assign fin = sf0;
    end else begin : g_body
      assign nin = num[k-1];
      assign rin = res[k-1];
      assign fin = sf[k-1];
    end
    assign trial = rin + BIT;
    assign ge    = nin >= trial;
    always_ff @(posedge clk) begin
      res[k] <= ge ? (rin >> 1) + BIT : rin >> 1;
      sf[k]  <= fin;
    end
    if (k < SQRT_STEPS) begin : g_num
      always_ff @(posedge clk) begin
        num[k] <= ge ? nin - trial : nin;
      end
    end
  end

  logic [SQRT_STEPS:0] rp1;
  logic [VAL_W-1:0]    mag;
  assign rp1 = {1'b0, res[SQRT_STEPS][SQRT_STEPS-1:0]} + (SQRT_STEPS+1)'(1);
  assign mag = rp1[SQRT_STEPS:1];

  always_ff @(posedge clk) begin
    if (sf[SQRT_STEPS].zero) begin
      value <= '0;
    end else if (sf[SQRT_STEPS].neg) begin
      value <= ~mag + VAL_W'(1);
    end else if (mag[VAL_W-1]) begin
      value <= {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      value <= mag;
    end
  end

endmodule

### rtl/lvp_front.sv
// ----------------------------------------------------------------------------
// lvp_front
// Basis set-up pipeline: squares, up-vector choice, cross products and the
// operand pairs per entry, then a sequencer issuing one column a cycle.
// ----------------------------------------------------------------------------
module lvp_front import lvp_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic signed [DIR_W-1:0]     dir_x,
  input  logic signed [DIR_W-1:0]     dir_y,
  input  logic signed [DIR_W-1:0]     dir_z,
  input  logic [E2_W-1:0]             e2,
  input  logic [E2_W-1:0]             h2,
  output tag_t                        iss_tag,
  output logic [NROW-1:0][A_W-1:0]    iss_a,
  output logic [NROW-1:0][B_W-1:0]    iss_b,
  output logic [NROW-1:0]             iss_neg
);

  logic [6:1] vld;

  logic [2:0][DIR_W-1:0] dir;
  assign dir = {dir_z, dir_y, dir_x};

  // stage 1: magnitudes and signs
  logic [2:0][MAG_W-1:0] ad1;
  logic [2:0]            pos1, ng1;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ad1[i]  <= dir[i][DIR_W-1] ? ~dir[i] + MAG_W'(1) : dir[i];
      pos1[i] <= !dir[i][DIR_W-1] && (dir[i] != '0);
      ng1[i]  <= dir[i][DIR_W-1];
    end
  end

  // stage 2: squares and pair products (pairs 01, 12, 02)
  logic [2:0][SQ_W-1:0] sq2, pm2;
  logic [2:0]           pp2, pos2, ng2;
  logic [2:0][2*MAG_W-1:0] sq_full, pm_full;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_full[i] = (2*MAG_W)'(ad1[i]) * (2*MAG_W)'(ad1[i]);
    end
    pm_full[0] = (2*MAG_W)'(ad1[0]) * (2*MAG_W)'(ad1[1]);
    pm_full[1] = (2*MAG_W)'(ad1[1]) * (2*MAG_W)'(ad1[2]);
    pm_full[2] = (2*MAG_W)'(ad1[0]) * (2*MAG_W)'(ad1[2]);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq2[i] <= sq_full[i][SQ_W-1:0];
      pm2[i] <= pm_full[i][SQ_W-1:0];
    end
    pp2[0] <= (pos1[0] && pos1[1]) || (ng1[0] && ng1[1]);
    pp2[1] <= (pos1[1] && pos1[2]) || (ng1[1] && ng1[2]);
    pp2[2] <= (pos1[0] && pos1[2]) || (ng1[0] && ng1[2]);
    pos2   <= pos1;
    ng2    <= ng1;
  end

  // stage 3: norms and the near-vertical scale products
  logic [N2_W-1:0]      n2_3, m2y3, m2x3;
  logic [VX_W-1:0]      vx3, vz3;
  logic [2:0][SQ_W-1:0] sq3, pm3;
  logic [2:0]           pp3, pos3, ng3;

  always_ff @(posedge clk) begin
    n2_3 <= N2_W'(sq2[0]) + N2_W'(sq2[1]) + N2_W'(sq2[2]);
    m2y3 <= N2_W'(sq2[0]) + N2_W'(sq2[2]);
    m2x3 <= N2_W'(sq2[1]) + N2_W'(sq2[2]);
    vx3  <= VX_W'(sq2[0]) * VERT_SCALE;
    vz3  <= VX_W'(sq2[2]) * VERT_SCALE;
    sq3  <= sq2;
    pm3  <= pm2;
    pp3  <= pp2;
    pos3 <= pos2;
    ng3  <= ng2;
  end

  // stage 4: up-vector choice, right and up components as magnitude and sign
  logic                 vert;
  logic [2:0][SQ_W-1:0] a0_4, a2_4;
  logic [2:0][N2_W-1:0] wm4;
  logic [2:0]           n0_4, n1_4, n2s_4;
  logic [N2_W-1:0]      m2_4, n2_4;
  logic                 deg4;

  assign vert = (vx3 < VX_W'(n2_3)) && (vz3 < VX_W'(n2_3));

  always_ff @(posedge clk) begin
    if (vert) begin
      a0_4 <= {sq3[1], sq3[2], SQ_W'(0)};
      n0_4 <= {pos3[1], ng3[2], 1'b0};
      wm4  <= {N2_W'(pm3[2]), N2_W'(pm3[0]), m2x3};
      n1_4 <= {pp3[2], pp3[0], 1'b0};
      m2_4 <= m2x3;
    end else begin
      a0_4 <= {sq3[0], SQ_W'(0), sq3[2]};
      n0_4 <= {ng3[0], 1'b0, pos3[2]};
      wm4  <= {N2_W'(pm3[1]), m2y3, N2_W'(pm3[0])};
      n1_4 <= {pp3[1], 1'b0, pp3[0]};
      m2_4 <= m2y3;
    end
    a2_4  <= sq3;
    n2s_4 <= pos3;
    n2_4  <= n2_3;
    deg4  <= n2_3 == '0;
  end

  // stage 5: squares of up, scale products and the norm product
  logic [2:0][SQ_W-1:0]     a0_5, a2_5;
  logic [2:0][A_W-1:0]      a1_5;
  logic [2:0]               n0_5, n1_5, n2s_5;
  logic [E2_W+N2_W-1:0]     b0_5, b2_5;
  logic [PNM_W-1:0]         pnm5;
  logic                     deg5;
  logic [2:0][2*N2_W-1:0]   w_full;
  logic [2*N2_W-1:0]        pnm_full;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w_full[i] = (2*N2_W)'(wm4[i]) * (2*N2_W)'(wm4[i]);
    end
    pnm_full = (2*N2_W)'(n2_4) * (2*N2_W)'(m2_4);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      a1_5[i] <= w_full[i][A_W-1:0];
    end
    b0_5  <= (E2_W+N2_W)'(e2) * (E2_W+N2_W)'(m2_4);
    b2_5  <= (E2_W+N2_W)'(h2) * (E2_W+N2_W)'(n2_4);
    pnm5  <= pnm_full[PNM_W-1:0];
    a0_5  <= a0_4;
    a2_5  <= a2_4;
    n0_5  <= n0_4;
    n1_5  <= n1_4;
    n2s_5 <= n2s_4;
    deg5  <= deg4;
  end

  // stage 6: partial products of the up-row scale
  logic [E2_W+PNM_W-LO_W-1:0] pph6;
  logic [E2_W+LO_W-1:0]       ppl6;
  logic [2:0][SQ_W-1:0]       a0_6, a2_6;
  logic [2:0][A_W-1:0]        a1_6;
  logic [2:0]                 n0_6, n1_6, n2s_6;
  logic [E2_W+N2_W-1:0]       b0_6, b2_6;
  logic                       deg6;

  always_ff @(posedge clk) begin
    pph6  <= (E2_W+PNM_W-LO_W)'(e2) * (E2_W+PNM_W-LO_W)'(pnm5[PNM_W-1:LO_W]);
    ppl6  <= (E2_W+LO_W)'(e2) * (E2_W+LO_W)'(pnm5[LO_W-1:0]);
    a0_6  <= a0_5;
    a1_6  <= a1_5;
    a2_6  <= a2_5;
    n0_6  <= n0_5;
    n1_6  <= n1_5;
    n2s_6 <= n2s_5;
    b0_6  <= b0_5;
    b2_6  <= b2_5;
    deg6  <= deg5;
  end

  // hold stage and column sequencer
  logic [A_W-1:0]   ha [NROW][NCOL];
  logic             hn [NROW][NCOL];
  logic [B_W-1:0]   hb [NROW];
  logic             hdeg;
  logic             seq_act;
  logic [COL_W-1:0] seq_cnt;

  always_ff @(posedge clk) begin
    if (vld[6]) begin
      for (int c = 0; c < NCOL - 1; c++) begin
        ha[0][c] <= A_W'(a0_6[c]);
        ha[1][c] <= a1_6[c];
        ha[2][c] <= A_W'(a2_6[c]);
        hn[0][c] <= n0_6[c];
        hn[1][c] <= n1_6[c];
        hn[2][c] <= n2s_6[c];
      end
      for (int r = 0; r < NROW; r++) begin
        ha[r][NCOL-1] <= '0;
        hn[r][NCOL-1] <= 1'b0;
      end
      hb[0] <= B_W'(b0_6);
      hb[1] <= (B_W'(pph6) << LO_W) + B_W'(ppl6);
      hb[2] <= B_W'(b2_6);
      hdeg  <= deg6;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      seq_act <= 1'b0;
      seq_cnt <= '0;
      iss_tag <= '0;
    end else begin
      vld <= {vld[5:1], accept};
      if (vld[6]) begin
        seq_act <= 1'b1;
        seq_cnt <= '0;
      end else if (seq_act) begin
        seq_act <= seq_cnt != LAST_COL;
        seq_cnt <= seq_cnt + COL_W'(1);
      end
      iss_tag.vld  <= seq_act;
      iss_tag.col  <= seq_cnt;
      iss_tag.deg  <= hdeg;
      iss_tag.last <= seq_cnt == LAST_COL;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < NROW; r++) begin
      iss_a[r]   <= ha[r][seq_cnt];
      iss_b[r]   <= hb[r];
      iss_neg[r] <= hn[r][seq_cnt];
    end
  end

endmodule

### rtl/light_ortho_view_projection.sv
// ----------------------------------------------------------------------------
// light_ortho_view_projection
// Light view-projection matrix builder: a direction word in, four column
// words out (column-major, fourth row constant), entries in signed fixed point.
//
//   channel   signals                                  handshake
//   input     dir_x dir_y dir_z                        start & !busy
//   result    column_index row0..2_value degenerate    strobe, one cycle
//             last_column
//   config    psel penable pwrite paddr pwdata prdata  apb, pready high
//
// a word is accepted only while busy is low; busy rises after each accept and
// spaces accepted words for the four column words each produces as results
// first column strobes after 7 set-up stages from the accepting edge (the first
// loads at that edge), one issue stage and the 50-stage divide and root unit;
// columns follow back to back
// synchronous reset clears the registers to their defaults and empties the
// pipeline; the receiver cannot stall, so nothing is held back
// ----------------------------------------------------------------------------
module light_ortho_view_projection import lvp_pkg::*; #(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [DIR_W-1:0] dir_x,
  input  logic signed [DIR_W-1:0] dir_y,
  input  logic signed [DIR_W-1:0] dir_z,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  output logic                    strobe,
  output logic [COL_W-1:0]        column_index,
  output logic signed [VAL_W-1:0] row0_value,
  output logic signed [VAL_W-1:0] row1_value,
  output logic signed [VAL_W-1:0] row2_value,
  output logic                    degenerate,
  output logic                    last_column
);

  localparam int GAP_W = $clog2(ITEM_GAP);

  logic [CFG_W-1:0] light_distance, ortho_half_extent, depth_half_range;
  logic [E2_W-1:0]  e2, h2;
  logic [GAP_W-1:0] gap_cnt;
  logic             accept, wr_en;
  logic [ADDR_W-3:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign accept  = start && !busy;
  assign busy    = gap_cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_distance    <= CFG_W'(3840);
      ortho_half_extent <= CFG_W'(768);
      depth_half_range  <= CFG_W'(512);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LIGHT_DISTANCE: light_distance    <= pwdata[CFG_W-1:0];
        REG_ORTHO_EXTENT:   ortho_half_extent <= pwdata[CFG_W-1:0];
        REG_DEPTH_RANGE:    depth_half_range  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LIGHT_DISTANCE: prdata = DATA_W'(light_distance);
      REG_ORTHO_EXTENT:   prdata = DATA_W'(ortho_half_extent);
      REG_DEPTH_RANGE:    prdata = DATA_W'(depth_half_range);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    e2 <= E2_W'(ortho_half_extent) * E2_W'(ortho_half_extent);
    h2 <= E2_W'(depth_half_range) * E2_W'(depth_half_range);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_cnt <= '0;
    end else if (accept) begin
      gap_cnt <= GAP_W'(ITEM_GAP - 1);
    end else if (busy) begin
      gap_cnt <= gap_cnt - GAP_W'(1);
    end
  end

  tag_t                     iss_tag;
  logic [NROW-1:0][A_W-1:0] iss_a;
  logic [NROW-1:0][B_W-1:0] iss_b;
  logic [NROW-1:0]          iss_neg;

  lvp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .dir_x   (dir_x),
    .dir_y   (dir_y),
    .dir_z   (dir_z),
    .e2      (e2),
    .h2      (h2),
    .iss_tag (iss_tag),
    .iss_a   (iss_a),
    .iss_b   (iss_b),
    .iss_neg (iss_neg)
  );

  logic [NROW-1:0][VAL_W-1:0] rv;

  for (genvar r = 0; r < NROW; r++) begin : g_row
    lvp_root #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_root (
      .clk   (clk),
      .a     (iss_a[r]),
      .b     (iss_b[r]),
      .neg   (iss_neg[r]),
      .value (rv[r])
    );
  end

  // column tag travels alongside the entry units
  tag_t tag_line [ROOT_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ROOT_LAT; k++) begin
        tag_line[k] <= '0;
      end
    end else begin
      tag_line[0] <= iss_tag;
      for (int k = 1; k < ROOT_LAT; k++) begin
        tag_line[k] <= tag_line[k-1];
      end
    end
  end

  assign strobe       = tag_line[ROOT_LAT-1].vld;
  assign column_index = tag_line[ROOT_LAT-1].col;
  assign degenerate   = tag_line[ROOT_LAT-1].deg;
  assign last_column  = tag_line[ROOT_LAT-1].last;
  assign row0_value   = rv[0];
  assign row1_value   = rv[1];
  assign row2_value   = rv[2];

endmodule
